@@ hw/rtl/kgbr_pkg.sv @@
// ----------------------------------------------------------------------------
// kgbr_pkg
// Shared widths and the group-size reset value for the k-group block reverser.
// ----------------------------------------------------------------------------
package kgbr_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CFG_W   = 5;

  localparam logic [CFG_W-1:0] GROUP_SIZE_RST = 5'd2;

endpackage

@@ hw/rtl/kgbr_front.sv @@
// ----------------------------------------------------------------------------
// kgbr_front
// Input side: writes words into the current bank and closes a group when it
// is full or the sequence ends, handing a drain command to the queue.
// ----------------------------------------------------------------------------
module kgbr_front #(
  parameter int unsigned MAX_GROUP = 16,
  parameter int unsigned CW        = $clog2(MAX_GROUP + 1),
  parameter int unsigned IW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [kgbr_pkg::CFG_W-1:0]          cfg_size_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [kgbr_pkg::VALUE_W-1:0] value_i,
  input  logic                                is_last_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output logic [CW+2:0]                       cmd_o,
  output logic [IW+1+kgbr_pkg::VALUE_W:0]     wr_o
);

  localparam int unsigned EW = (CW > kgbr_pkg::CFG_W) ? CW : kgbr_pkg::CFG_W;

  typedef struct packed {
    logic          bank;
    logic [CW-1:0] count;
    logic          rev;
    logic          last;
  } cmd_t;

  typedef struct packed {
    logic                         en;
    logic [IW:0]                  addr;
    logic [kgbr_pkg::VALUE_W-1:0] data;
  } wr_t;

  logic [CW-1:0] fill_q, fill_d;
  logic          bank_q, bank_d;
  logic [EW-1:0] eff_size;
  logic [EW-1:0] fill_next;
  logic          accept;
  logic          full;
  cmd_t          cmd;
  wr_t           wr;

  // zero behaves as one, oversize saturates
  always_comb begin
    if (cfg_size_i == '0) begin
      eff_size = EW'(1);
    end else if (EW'(cfg_size_i) > EW'(MAX_GROUP)) begin
      eff_size = EW'(MAX_GROUP);
    end else begin
      eff_size = EW'(cfg_size_i);
    end
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign fill_next  = EW'(fill_q) + EW'(1);
  assign full       = fill_next >= eff_size;
  assign push_o     = accept && (full || is_last_i);

  always_comb begin
    cmd.bank  = bank_q;
    cmd.count = fill_next[CW-1:0];
    cmd.rev   = full;
    cmd.last  = is_last_i;
    wr.en     = accept;
    wr.addr   = {bank_q, fill_q[IW-1:0]};
    wr.data   = value_i;
  end

  assign cmd_o = cmd;
  assign wr_o  = wr;

  always_comb begin
    fill_d = fill_q;
    bank_d = bank_q;
    if (push_o) begin
      fill_d = '0;
      bank_d = !bank_q;
    end else if (accept) begin
      fill_d = fill_next[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bank_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      bank_q <= bank_d;
    end
  end

endmodule

@@ hw/rtl/kgbr_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// kgbr_cmd_fifo
// Two-entry command queue between front and back; one entry per bank.
// ----------------------------------------------------------------------------
module kgbr_cmd_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         full_o,
  output logic         valid_o
);

  logic [W-1:0] mem_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q, cnt_d;

  assign data_o  = mem_q[rptr_q];
  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
    end
  end

endmodule

@@ hw/rtl/kgbr_back.sv @@
// ----------------------------------------------------------------------------
// kgbr_back
// Output side: holds the two-bank group buffer and drains the queued group,
// reversed or in order, into the output register: one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module kgbr_back #(
  parameter int unsigned MAX_GROUP = 16,
  parameter int unsigned CW        = $clog2(MAX_GROUP + 1),
  parameter int unsigned IW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [IW+1+kgbr_pkg::VALUE_W:0]     wr_i,
  input  logic                                head_valid_i,
  input  logic [CW+2:0]                       head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [kgbr_pkg::VALUE_W-1:0] out_value_o,
  output logic                                out_last_o
);

  typedef struct packed {
    logic          bank;
    logic [CW-1:0] count;
    logic          rev;
    logic          last;
  } cmd_t;

  typedef struct packed {
    logic                         en;
    logic [IW:0]                  addr;
    logic [kgbr_pkg::VALUE_W-1:0] data;
  } wr_t;

  logic [kgbr_pkg::VALUE_W-1:0] mem_q [2 * (2 ** IW)];
  logic [kgbr_pkg::VALUE_W-1:0] out_value_q;
  logic                         out_last_q;
  logic                         out_valid_q;
  logic [CW-1:0]                idx_q;
  logic [CW-1:0]                pos;
  logic                         at_end;
  logic                         issue;
  cmd_t                         head;
  wr_t                          wr;

  assign head   = head_i;
  assign wr     = wr_i;
  assign at_end = idx_q == (head.count - CW'(1));
  assign pos    = head.rev ? (head.count - CW'(1) - idx_q) : idx_q;
  assign issue  = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o  = issue && at_end;

  always_ff @(posedge clk_i) begin
    if (wr.en) begin
      mem_q[wr.addr] <= wr.data;
    end
  end

  // registered read straight into the output word
  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_value_q <= mem_q[{head.bank, pos[IW-1:0]}];
      out_last_q  <= head.last && at_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (issue) begin
        out_valid_q <= 1'b1;
        idx_q       <= at_end ? '0 : idx_q + CW'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = $signed(out_value_q);
  assign out_last_o  = out_last_q;

endmodule

@@ hw/rtl/k_group_block_reverser_unit.sv @@
// ----------------------------------------------------------------------------
// k_group_block_reverser_unit
// Reverses a word stream in groups of group_size; a trailing partial group
// leaves in its original order.
// ----------------------------------------------------------------------------
// Usage:
//   in   : in_valid_i/in_ready_o with value_i and is_last_i, one word a cycle while ready.
//   out  : out_valid_o/out_ready_i with out_value_o and out_last_o.
//   cfg  : cfg_valid_i/cfg_ready_o with cfg_data_i (group_size, reset 2);
//          always ready, write only while the stream is idle. Zero acts as
//          one, values above MAX_GROUP act as MAX_GROUP.
//   Order: the word that closes a group is written with its queued command; the
//   output register then takes the group's words one per cycle while not stalled.
//   Throughput: input takes one word per cycle and output gives one word per
//   cycle; on average one word in and one out every cycle, set by the single
//   read port of the group buffer. The buffer has two banks, so one group
//   fills while the previous one drains; in_ready_o drops while two closed
//   groups wait, until the older one finishes draining.
//   Reset: buffer fill and queue are emptied, group_size returns to 2.
//   A stalled receiver holds the output word; the queue then fills and the
//   input side stalls in turn. No word is dropped.
// ----------------------------------------------------------------------------
module k_group_block_reverser_unit #(
  parameter int unsigned MAX_GROUP = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [kgbr_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [kgbr_pkg::VALUE_W-1:0] value_i,
  input  logic                                is_last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [kgbr_pkg::VALUE_W-1:0] out_value_o,
  output logic                                out_last_o
);

  localparam int unsigned CW = $clog2(MAX_GROUP + 1);
  localparam int unsigned IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  logic [kgbr_pkg::CFG_W-1:0]     group_size_q;
  logic                           push;
  logic                           pop;
  logic                           q_full;
  logic                           head_valid;
  logic [CW+2:0]                  cmd;
  logic [CW+2:0]                  head;
  logic [IW+1+kgbr_pkg::VALUE_W:0] wr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= kgbr_pkg::GROUP_SIZE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      group_size_q <= cfg_data_i;
    end
  end

  kgbr_front #(
    .MAX_GROUP (MAX_GROUP),
    .CW        (CW),
    .IW        (IW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_size_i (group_size_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .is_last_i  (is_last_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd),
    .wr_o       (wr)
  );

  kgbr_cmd_fifo #(
    .W (CW + 3)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd),
    .pop_i   (pop),
    .data_o  (head),
    .full_o  (q_full),
    .valid_o (head_valid)
  );

  kgbr_back #(
    .MAX_GROUP (MAX_GROUP),
    .CW        (CW),
    .IW        (IW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_value_o  (out_value_o),
    .out_last_o   (out_last_o)
  );

endmodule

@@ hw/rtl/kgbr_checker.sv @@
// ----------------------------------------------------------------------------
// kgbr_checker
// Port-level checks: word conservation, sequence ends, input stalls and output hold.
// ----------------------------------------------------------------------------
module kgbr_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                is_last_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [kgbr_pkg::VALUE_W-1:0] out_value_o,
  input logic                                out_last_o
);

  logic       in_acc;
  logic       out_acc;
  logic [8:0] words_q;
  logic [8:0] ends_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // words accepted but not yet delivered, and sequence ends still owed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= '0;
      ends_q  <= '0;
    end else begin
      words_q <= words_q + 9'(in_acc) - 9'(out_acc);
      ends_q  <= ends_q + 9'(in_acc && is_last_i) - 9'(out_acc && out_last_o);
    end
  end

  a_no_invented_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> words_q != 9'd0)
    else $error("output word with no accepted input outstanding");

  a_last_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_last_o) |-> ends_q != 9'd0)
    else $error("last flag without a pending sequence end");

  a_stall_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> words_q != 9'd0)
    else $error("input stalled while block is empty");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(out_value_o) && $stable(out_last_o)))
    else $error("stalled output word changed");

endmodule

bind k_group_block_reverser_unit kgbr_checker u_kgbr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .is_last_i   (is_last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_value_o (out_value_o),
  .out_last_o  (out_last_o)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for k_group_block_reverser_unit. A short table of
// directed words and size writes runs first, then random sequences under
// several group sizes and idle/stall mixes. Every output word is compared
// with a software reorder of the accepted input or a table row's typed word.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MAX_G      = 16;
  localparam int unsigned DRAIN_WAIT = 8;
  localparam int unsigned CYCLE_CAP  = 200000;

  typedef enum logic {ROW_WORD, ROW_SIZE} row_kind_e;

  typedef struct packed {
    row_kind_e                    kind;
    logic [kgbr_pkg::CFG_W-1:0]   size;
    logic [kgbr_pkg::VALUE_W-1:0] val;
    logic                         last;
    logic                         typed;
    logic [kgbr_pkg::VALUE_W-1:0] exp_val;
    logic                         exp_last;
  } row_t;

  typedef struct packed {
    logic [kgbr_pkg::VALUE_W-1:0] val;
    logic                         last;
  } word_t;

  logic                                clk_i       = 1'b0;
  logic                                rst_ni      = 1'b0;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [kgbr_pkg::CFG_W-1:0]          cfg_data_i  = '0;
  logic                                in_valid_i  = 1'b0;
  logic                                in_ready_o;
  logic signed [kgbr_pkg::VALUE_W-1:0] value_i     = '0;
  logic                                is_last_i   = 1'b0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic signed [kgbr_pkg::VALUE_W-1:0] out_value_o;
  logic                                out_last_o;

  k_group_block_reverser_unit #(.MAX_GROUP(MAX_G)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .is_last_i  (is_last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_value_o(out_value_o),
    .out_last_o (out_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // directed words; typed expectations only where one word comes straight out
  localparam int unsigned N_ROWS = 29;
  localparam row_t dir_tab [0:N_ROWS-1] = '{
    '{ROW_WORD, 5'd0,  32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'h8000_0000, 1'b1, 1'b0, 32'h0,         1'b0},
    '{ROW_SIZE, 5'd1,  32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{ROW_WORD, 5'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
    '{ROW_SIZE, 5'd0,  32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, 1'b0},
    '{ROW_WORD, 5'd0,  32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1},
    '{ROW_SIZE, 5'd3,  32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'h0000_0011, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'h0000_0022, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'h0000_0033, 1'b1, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'h0000_0044, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'h0000_0055, 1'b1, 1'b0, 32'h0,         1'b0},
    '{ROW_SIZE, 5'd31, 32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'h5A5A_5A5A, 1'b1, 1'b0, 32'h0,         1'b0},
    '{ROW_SIZE, 5'd16, 32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'h0000_0001, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'h0000_0002, 1'b1, 1'b0, 32'h0,         1'b0},
    '{ROW_SIZE, 5'd4,  32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'hDEAD_0001, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'hDEAD_0002, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'hDEAD_0003, 1'b0, 1'b0, 32'h0,         1'b0},
    // shrink the size with three words held: next word flushes all four
    '{ROW_SIZE, 5'd2,  32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'hDEAD_0004, 1'b1, 1'b0, 32'h0,         1'b0},
    '{ROW_SIZE, 5'd17, 32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'h0000_0007, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WORD, 5'd0,  32'h0000_0008, 1'b1, 1'b0, 32'h0,         1'b0}
  };

  // reorder model state
  logic [kgbr_pkg::CFG_W-1:0]   grp_size = kgbr_pkg::GROUP_SIZE_RST;
  logic [kgbr_pkg::VALUE_W-1:0] held_words [0:MAX_G-1];
  int unsigned                  held_cnt = 0;
  word_t                        pend [0:MAX_G-1];
  word_t                        out_due_q [$];

  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  function automatic int unsigned eff_size(input logic [kgbr_pkg::CFG_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_G) return MAX_G;
    return 32'(s);
  endfunction

  // fills pend[0..n-1] with the words this input releases
  task automatic reorder_step(input logic [kgbr_pkg::VALUE_W-1:0] v, input logic l,
                              output int unsigned n);
    int unsigned sz;
    sz = eff_size(grp_size);
    n = 0;
    if (held_cnt < MAX_G) begin
      held_words[held_cnt] = v;
      held_cnt++;
    end
    if (held_cnt >= sz) begin
      for (int unsigned i = 0; i < held_cnt; i++) begin
        pend[n] = '{held_words[held_cnt-1-i], 1'b0};
        n++;
      end
      held_cnt = 0;
    end else if (l) begin
      for (int unsigned i = 0; i < held_cnt; i++) begin
        pend[n] = '{held_words[i], 1'b0};
        n++;
      end
      held_cnt = 0;
    end
    if (l && n > 0) pend[n-1].last = 1'b1;
  endtask

  task automatic flag_mismatch(input string what,
                               input logic [kgbr_pkg::VALUE_W-1:0] got,
                               input logic [kgbr_pkg::VALUE_W-1:0] want);
    $display("MISMATCH %s: got %h, want %h", what, got, want);
    err_cnt++;
  endtask

  task automatic send_word(input logic [kgbr_pkg::VALUE_W-1:0] v, input logic l,
                           input logic typed, input word_t typed_word);
    int unsigned n;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    is_last_i  <= l;
    do @(posedge clk_i); while (!in_ready_o);
    reorder_step(v, l, n);
    if (typed) out_due_q.push_back(typed_word);
    else for (int unsigned i = 0; i < n; i++) out_due_q.push_back(pend[i]);
  endtask

  task automatic drain_out();
    in_valid_i <= 1'b0;
    while (out_due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [kgbr_pkg::CFG_W-1:0] s);
    drain_out();
    // a held partial group gives no word, so leave the block some settle time
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= s;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    grp_size = s;
  endtask

  function automatic logic [kgbr_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // output check, then new ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (out_due_q.size() == 0) begin
        flag_mismatch("word with nothing due", out_value_o, '0);
      end else begin
        word_t due;
        due = out_due_q.pop_front();
        if (out_value_o !== due.val) flag_mismatch("out_value", out_value_o, due.val);
        if (out_last_o !== due.last)
          flag_mismatch("out_last", 32'(out_last_o), 32'(due.last));
      end
    end
    out_ready_i <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned seg_items;
    int unsigned len;
    int unsigned sz;
    logic [kgbr_pkg::CFG_W-1:0] s;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned r = 0; r < N_ROWS; r++) begin
      if (dir_tab[r].kind == ROW_SIZE) write_size(dir_tab[r].size);
      else send_word(dir_tab[r].val, dir_tab[r].last, dir_tab[r].typed,
                     '{dir_tab[r].exp_val, dir_tab[r].exp_last});
    end

    for (int unsigned seg = 0; seg < 12; seg++) begin
      case (seg / 3)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      case (seg % 6)
        0: s = 5'd1;
        1: s = 5'd16;
        2: s = 5'($urandom_range(2, 5));
        3: s = 5'd0;
        4: s = 5'($urandom_range(2, 8));
        default: s = ($urandom_range(1) != 0) ? 5'd31 : 5'd17;
      endcase
      write_size(s);
      sz = eff_size(s);
      seg_items = 0;
      while (seg_items < 20) begin
        // now and then hold the sender until the output has caught up
        if ($urandom_range(39) == 0) drain_out();
        if ($urandom_range(3) == 0 && sz <= 15) len = sz * $urandom_range(1, 2);
        else len = $urandom_range(1, (3 * sz > 30) ? 30 : 3 * sz);
        for (int unsigned k = 0; k < len; k++)
          send_word(pick_value(), k == len - 1, 1'b0, '0);
        seg_items += len;
      end
    end

    drain_out();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
